FILE: hw/rtl/utu_pkg.sv
package utu_pkg;

  // Result kinds carried on out_tuser
  typedef enum logic [2:0] {
    ST_UNIT      = 3'd0,
    ST_DOC_OK    = 3'd1,
    ST_BAD_LEAD  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_BAD_CONT  = 3'd4,
    ST_ILLEGAL   = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] unit;
    status_t     status;
    logic        last;
  } res_t;

  // Most results one byte can cause: surrogate pair plus end-of-document status
  localparam int MaxRes = 3;

  localparam logic [20:0] MinLen2   = 21'h000080;
  localparam logic [20:0] MinLen3   = 21'h000800;
  localparam logic [20:0] MinLen4   = 21'h010000;
  localparam logic [20:0] SurrLo    = 21'h00D800;
  localparam logic [20:0] SurrHi    = 21'h00DFFF;
  localparam logic [20:0] MaxCode   = 21'h10FFFF;
  localparam logic [20:0] BomCode   = 21'h00FEFF;
  localparam logic [5:0]  HiSurrTag = 6'b110110;
  localparam logic [5:0]  LoSurrTag = 6'b110111;

endpackage

FILE: hw/rtl/utu_dec.sv
module utu_dec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             strip_bom,
  input  logic [7:0]       data_byte,
  input  logic             end_of_doc,
  input  logic             commit,
  output utu_pkg::res_t    res_o [utu_pkg::MaxRes],
  output logic [1:0]       res_cnt_o
);

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  owed_r, owed_nxt;
  logic [2:0]  seq_len_r, seq_len_nxt;
  logic        doc_start_r, doc_start_nxt;
  logic        err_r, err_nxt;

  always_comb begin
    logic [1:0]  k;
    logic        fin;
    logic [20:0] cp;
    logic [2:0]  len;
    logic [20:0] minimum;
    logic [20:0] pc;
    logic [19:0] v;

    partial_nxt   = partial_r;
    owed_nxt      = owed_r;
    seq_len_nxt   = seq_len_r;
    doc_start_nxt = doc_start_r;
    err_nxt       = err_r;
    k             = 2'd0;
    fin           = 1'b0;
    cp            = '0;
    len           = seq_len_r;
    minimum       = '0;
    pc            = {partial_r[14:0], data_byte[5:0]};
    v             = '0;
    for (int i = 0; i < utu_pkg::MaxRes; i++) begin
      res_o[i] = '{unit: 16'h0000, status: utu_pkg::ST_UNIT, last: 1'b0};
    end

    if (!err_r) begin
      if (owed_r == 2'd0) begin
        if (data_byte[7] == 1'b0) begin
          fin = 1'b1;
          cp  = {13'd0, data_byte};
          len = 3'd1;
          seq_len_nxt = 3'd1;
        end else if (data_byte[7:5] == 3'b110) begin
          seq_len_nxt = 3'd2;
          partial_nxt = {16'd0, data_byte[4:0]};
          owed_nxt    = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          seq_len_nxt = 3'd3;
          partial_nxt = {17'd0, data_byte[3:0]};
          owed_nxt    = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          seq_len_nxt = 3'd4;
          partial_nxt = {18'd0, data_byte[2:0]};
          owed_nxt    = 2'd3;
        end else begin
          res_o[k].status = utu_pkg::ST_BAD_LEAD;
          k       = k + 2'd1;
          err_nxt = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        res_o[k].status = utu_pkg::ST_BAD_CONT;
        k       = k + 2'd1;
        err_nxt = 1'b1;
      end else begin
        owed_nxt = owed_r - 2'd1;
        if (owed_r == 2'd1) begin
          fin = 1'b1;
          cp  = pc;
        end else begin
          partial_nxt = pc;
        end
      end
    end

    if (fin) begin
      case (len)
        3'd2:    minimum = utu_pkg::MinLen2;
        3'd3:    minimum = utu_pkg::MinLen3;
        3'd4:    minimum = utu_pkg::MinLen4;
        default: minimum = '0;
      endcase
      doc_start_nxt = 1'b0;
      partial_nxt   = '0;
      v             = cp[19:0] - 20'h10000;
      if (cp < minimum || (cp >= utu_pkg::SurrLo && cp <= utu_pkg::SurrHi) ||
          cp > utu_pkg::MaxCode) begin
        res_o[k].status = utu_pkg::ST_ILLEGAL;
        k       = k + 2'd1;
        err_nxt = 1'b1;
      end else if (doc_start_r && strip_bom && cp == utu_pkg::BomCode) begin
        // leading byte-order mark is swallowed
      end else if (cp >= utu_pkg::MinLen4) begin
        res_o[k].unit = {utu_pkg::HiSurrTag, v[19:10]};
        k = k + 2'd1;
        res_o[k].unit = {utu_pkg::LoSurrTag, v[9:0]};
        k = k + 2'd1;
      end else begin
        res_o[k].unit = cp[15:0];
        k = k + 2'd1;
      end
    end

    if (end_of_doc) begin
      if (!err_nxt) begin
        res_o[k].status = (owed_nxt != 2'd0) ? utu_pkg::ST_TRUNCATED : utu_pkg::ST_DOC_OK;
        k = k + 2'd1;
      end
      partial_nxt   = '0;
      owed_nxt      = 2'd0;
      seq_len_nxt   = 3'd0;
      doc_start_nxt = 1'b1;
      err_nxt       = 1'b0;
    end

    for (int i = 0; i < utu_pkg::MaxRes; i++) begin
      res_o[i].last = (k != 2'd0) && (2'(i) == k - 2'd1);
    end
    res_cnt_o = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      owed_r      <= 2'd0;
      seq_len_r   <= 3'd0;
      doc_start_r <= 1'b1;
      err_r       <= 1'b0;
    end else if (commit) begin
      partial_r   <= partial_nxt;
      owed_r      <= owed_nxt;
      seq_len_r   <= seq_len_nxt;
      doc_start_r <= doc_start_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

FILE: hw/rtl/utu_fifo.sv
module utu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [1:0]                 push_cnt,
  input  utu_pkg::res_t              push_data [utu_pkg::MaxRes],
  output logic [$clog2(DEPTH+1)-1:0] free_o,
  output logic                       out_valid,
  input  logic                       out_ready,
  output utu_pkg::res_t              out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  utu_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;
  logic [1:0]    add_cnt;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] p, logic [1:0] n);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(n);
    if (s >= (PW+1)'(DEPTH)) s = s - (PW+1)'(DEPTH);
    return s[PW-1:0];
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_r];
  assign free_o    = CW'(DEPTH) - count_r;
  assign add_cnt   = push ? push_cnt : 2'd0;

  always_comb begin
    wr_nxt    = wrap_add(wr_r, add_cnt);
    rd_nxt    = pop ? wrap_add(rd_r, 2'd1) : rd_r;
    count_nxt = count_r + CW'(add_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < utu_pkg::MaxRes; i++) begin
      if (push && 2'(i) < push_cnt) begin
        mem_r[wrap_add(wr_r, 2'(i))] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/utf8_to_utf16_transcoder_unit.sv
// Strict UTF-8 to UTF-16 transcoder. Takes one byte per cycle (in_tlast on the
// final byte of a document) and returns UTF-16 units, a document-ok status, or
// one error status per document, after which bytes are dropped until in_tlast.
// A byte is held in an input register, decoded combinationally and its 0 to 3
// results are written at once into a RES_DEPTH-entry result queue that drives
// the output, one result per cycle while out_tready is high. A byte's results
// pass through the input register and then the queue. Bytes are taken every
// cycle while out_tready is high and each yields at most one result on average;
// a byte finishing a supplementary code point yields two units (three with the
// end-of-document status), and the input then waits while the queue lacks room
// for all results of the held byte. cfg_wr_data sets strip_bom (reset 1).
module utf8_to_utf16_transcoder_unit #(
  parameter int RES_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_document
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // code_unit
  output logic [2:0]  out_tuser,  // status
  output logic        out_tlast   // last_of_run
);

  localparam int CW = $clog2(RES_DEPTH + 1);

  logic          strip_r;
  logic [7:0]    byte_r;
  logic          eod_r;
  logic          vld_r, vld_nxt;
  logic          go;
  logic          in_acc;
  logic [1:0]    res_cnt;
  logic [CW-1:0] free;
  utu_pkg::res_t res     [utu_pkg::MaxRes];
  utu_pkg::res_t out_res;

  utu_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .strip_bom (strip_r),
    .data_byte (byte_r),
    .end_of_doc(eod_r),
    .commit    (go),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  utu_fifo #(.DEPTH(RES_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (go),
    .push_cnt (res_cnt),
    .push_data(res),
    .free_o   (free),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_res)
  );

  assign go        = vld_r && (CW'(res_cnt) <= free);
  assign in_tready = !vld_r || go;
  assign in_acc    = in_tvalid && in_tready;
  assign vld_nxt   = in_acc ? 1'b1 : (go ? 1'b0 : vld_r);

  assign out_tdata = out_res.unit;
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r <= 1'b1;
      vld_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) strip_r <= cfg_wr_data;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      eod_r  <= in_tlast;
    end
  end

  // Any status other than a code unit closes the results of its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != utu_pkg::ST_UNIT |-> out_tlast)
    else $error("status result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != utu_pkg::ST_UNIT |-> out_tdata == 16'h0000)
    else $error("status result carries nonzero unit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !vld_r)
    else $error("pipeline not empty after reset");

endmodule
